/* design/pga_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pga_pkg;

    localparam int PAGE_W  = 15;
    localparam int COUNT_W = 8;
    localparam int PAGE_SPAN = 1 << PAGE_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        KIND_ALLOC = 2'd0,
        KIND_FREE  = 2'd1,
        KIND_INC   = 2'd2,
        KIND_DEC   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        STAT_OK    = 3'd0,
        STAT_EMPTY = 3'd1,
        STAT_BAD   = 3'd2,
        STAT_FULL  = 3'd3,
        STAT_OVER  = 3'd4,
        STAT_UNDER = 3'd5
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic               en;
        logic [PAGE_W-1:0]  page;
        logic [COUNT_W-1:0] count;
    } rc_wr_t;

endpackage

`default_nettype wire

/* design/page_allocator_with_refcounts.sv */
`timescale 1ns / 1ps
`default_nettype none

// Page frame allocator with per-page reference counts.
// Input channel (in_valid/in_ready): kind and page_index. Allocate pops the
// free stack or hands out the highest never-used page; free pushes a page;
// increment and decrement adjust the count, and a decrement to zero returns
// the page to the stack. Output channel (out_valid/out_ready) carries one
// result per item: status, result_page, ref_count, page_released, free_count.
// out_valid rises as the item leaves the execute state after its transfer.
// in_ready is low in execute, set by the read-then-write of the count and
// stack memories (read in the transfer cycle, modified and written in execute).
// Reset: the count memory is swept to zero, one entry per cycle over
// min(NUM_PAGES, 32768) entries, with in_ready low; cfg_we writes are taken
// at any time and first_usable_page resets to 0.
// Stall: one finished result is held in the output register; the next item
// is still accepted and waits in execute until that result is transferred.
module page_allocator_with_refcounts #(
    parameter int NUM_PAGES = 32768
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] first_usable_page,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  kind,
    input  wire logic [14:0] page_index,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [14:0]      result_page,
    output logic [7:0]       ref_count,
    output logic             page_released,
    output logic [15:0]      free_count
);

    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    localparam int SA_W  = $clog2(NUM_PAGES);
    localparam int CMP_W = ((CNT_W > 16) ? CNT_W : 16) + 1;
    localparam int PW    = pga_pkg::PAGE_W;
    localparam int CW    = pga_pkg::COUNT_W;

    pga_pkg::state_t  state_reg;
    pga_pkg::state_t  state_next;
    pga_pkg::kind_t   kind_reg;
    logic [PW-1:0]    page_reg;
    logic [15:0]      fup_reg;
    logic [CNT_W-1:0] depth_reg;
    logic [CNT_W-1:0] depth_next;
    logic [CNT_W-1:0] top_reg;
    logic [CNT_W-1:0] top_next;

    logic             out_valid_reg;
    logic [2:0]       status_reg;
    logic [PW-1:0]    result_page_reg;
    logic [CW-1:0]    ref_count_reg;
    logic             released_reg;
    logic [15:0]      free_count_reg;

    logic             in_fire;
    logic             exec_fire;
    logic             clear_done;
    logic [CW-1:0]    rc_rd;
    pga_pkg::rc_wr_t  rc_wr;

    logic [PW-1:0]    stack_mem [NUM_PAGES];
    logic [PW-1:0]    st_rd_reg;
    logic [SA_W-1:0]  st_raddr;
    logic             st_we;

    logic [CMP_W-1:0] fup_w;
    logic [CMP_W-1:0] top_w;
    logic [CMP_W-1:0] depth_w;
    logic [CMP_W-1:0] num_w;
    logic [CMP_W-1:0] page_w;
    logic [CMP_W-1:0] fresh_pg;
    logic [CMP_W-1:0] fresh_cnt;
    logic [CMP_W-1:0] capacity;
    logic [CMP_W-1:0] total;
    logic [CMP_W-1:0] total_after;
    logic             can_push;
    logic             in_range;
    logic             bad;
    logic [CW-1:0]    cnt;

    pga_pkg::status_t st_v;
    logic [PW-1:0]    res_page_v;
    logic [CW-1:0]    res_count_v;
    logic             released_v;
    logic             push_v;
    logic             take_v;
    logic             pop_v;

    // -------- control --------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pga_pkg::ST_IDLE:
                if (in_valid && clear_done)
                    state_next = pga_pkg::ST_EXEC;
            pga_pkg::ST_EXEC:
                if (!out_valid_reg || out_ready)
                    state_next = pga_pkg::ST_IDLE;
            default:
                state_next = pga_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            pga_pkg::ST_IDLE:
                in_ready = clear_done;
            pga_pkg::ST_EXEC:
                exec_fire = !out_valid_reg || out_ready;
            default:
            begin
                in_ready  = 1'b0;
                exec_fire = 1'b0;
            end
        endcase
    end

    assign in_fire = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pga_pkg::ST_IDLE;
            depth_reg     <= '0;
            top_reg       <= CNT_W'(NUM_PAGES);
            fup_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                fup_reg <= first_usable_page;
            if (exec_fire)
            begin
                depth_reg <= depth_next;
                top_reg   <= top_next;
            end
            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // -------- item capture and memory reads --------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            kind_reg <= pga_pkg::kind_t'(kind);
            page_reg <= page_index;
        end
    end

    assign st_raddr = SA_W'(depth_reg - CNT_W'(1));

    always_ff @(posedge clk)
    begin
        if (in_fire)
            st_rd_reg <= stack_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
            stack_mem[depth_reg[SA_W-1:0]] <= page_reg;
    end

    pga_refmem #(
        .NUM_PAGES (NUM_PAGES)
    ) u_refmem (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_en      (in_fire),
        .rd_page    (page_index),
        .rd_count   (rc_rd),
        .wr         (rc_wr),
        .clear_done (clear_done)
    );

    // -------- execute --------
    assign fup_w     = CMP_W'(fup_reg);
    assign top_w     = CMP_W'(top_reg);
    assign depth_w   = CMP_W'(depth_reg);
    assign num_w     = CMP_W'(NUM_PAGES);
    assign page_w    = CMP_W'(page_reg);
    assign fresh_pg  = top_w - CMP_W'(1);
    assign fresh_cnt = (top_w > fup_w) ? (top_w - fup_w) : '0;
    assign capacity  = (num_w > fup_w) ? (num_w - fup_w) : '0;
    assign total     = depth_w + fresh_cnt;
    assign can_push  = (total < capacity) && (depth_w < num_w);
    assign in_range  = page_w < num_w;
    assign bad       = !in_range || (page_w < fup_w);
    assign cnt       = in_range ? rc_rd : '0;

    always_comb
    begin
        st_v        = pga_pkg::STAT_OK;
        res_page_v  = page_reg;
        res_count_v = cnt;
        released_v  = 1'b0;
        push_v      = 1'b0;
        take_v      = 1'b0;
        pop_v       = 1'b0;
        rc_wr.en    = 1'b0;
        rc_wr.page  = page_reg;
        rc_wr.count = cnt;

        unique case (kind_reg)
            pga_pkg::KIND_ALLOC:
            begin
                res_count_v = CW'(1);
                rc_wr.count = CW'(1);
                if (depth_reg != '0)
                begin
                    pop_v      = 1'b1;
                    res_page_v = st_rd_reg;
                    rc_wr.en   = 1'b1;
                    rc_wr.page = st_rd_reg;
                end
                else if (fresh_cnt != '0)
                begin
                    take_v     = 1'b1;
                    res_page_v = fresh_pg[PW-1:0];
                    rc_wr.page = fresh_pg[PW-1:0];
                    // fresh pages beyond the index space are never read back
                    rc_wr.en   = fresh_pg < CMP_W'(pga_pkg::PAGE_SPAN);
                end
                else
                begin
                    st_v        = pga_pkg::STAT_EMPTY;
                    res_page_v  = '0;
                    res_count_v = '0;
                end
            end
            pga_pkg::KIND_FREE:
            begin
                if (bad)
                    st_v = pga_pkg::STAT_BAD;
                else if (can_push)
                    push_v = 1'b1;
                else
                    st_v = pga_pkg::STAT_FULL;
            end
            pga_pkg::KIND_INC:
            begin
                if (bad)
                    st_v = pga_pkg::STAT_BAD;
                else if (cnt == pga_pkg::COUNT_MAX)
                    st_v = pga_pkg::STAT_OVER;
                else
                begin
                    res_count_v = cnt + CW'(1);
                    rc_wr.en    = 1'b1;
                    rc_wr.count = cnt + CW'(1);
                end
            end
            pga_pkg::KIND_DEC:
            begin
                if (bad)
                    st_v = pga_pkg::STAT_BAD;
                else if (cnt == '0)
                    st_v = pga_pkg::STAT_UNDER;
                else
                begin
                    res_count_v = cnt - CW'(1);
                    rc_wr.en    = 1'b1;
                    rc_wr.count = cnt - CW'(1);
                    // last reference gone: return the page if there is room
                    if (cnt == CW'(1))
                    begin
                        if (can_push)
                        begin
                            push_v     = 1'b1;
                            released_v = 1'b1;
                        end
                        else
                            st_v = pga_pkg::STAT_FULL;
                    end
                end
            end
            default:
                st_v = pga_pkg::STAT_OK;
        endcase

        rc_wr.en = rc_wr.en && exec_fire;
    end

    assign st_we       = exec_fire && push_v;
    assign total_after = total + CMP_W'(push_v) - CMP_W'(pop_v || take_v);

    always_comb
    begin
        depth_next = depth_reg;
        top_next   = top_reg;
        if (push_v)
            depth_next = depth_reg + CNT_W'(1);
        else if (pop_v)
            depth_next = depth_reg - CNT_W'(1);
        if (take_v)
            top_next = top_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg      <= st_v;
            result_page_reg <= res_page_v;
            ref_count_reg   <= res_count_v;
            released_reg    <= released_v;
            free_count_reg  <= total_after[15:0];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign result_page   = result_page_reg;
    assign ref_count     = ref_count_reg;
    assign page_released = released_reg;
    assign free_count    = free_count_reg;

endmodule

`default_nettype wire

/* design/pga_refmem.sv */
`timescale 1ns / 1ps
`default_nettype none

module pga_refmem #(
    parameter int NUM_PAGES = 32768
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        rd_en,
    input  wire logic [pga_pkg::PAGE_W-1:0]  rd_page,
    output logic      [pga_pkg::COUNT_W-1:0] rd_count,
    input  wire pga_pkg::rc_wr_t             wr,
    output logic                             clear_done
);

    // Pages above the 15-bit index space are never read back.
    localparam int RC_DEPTH = (NUM_PAGES < pga_pkg::PAGE_SPAN) ? NUM_PAGES
                                                               : pga_pkg::PAGE_SPAN;
    localparam int RA_W = $clog2(RC_DEPTH);

    logic [pga_pkg::COUNT_W-1:0] mem [RC_DEPTH];
    logic [RA_W-1:0]             clr_addr_reg;
    logic [RA_W-1:0]             clr_addr_next;
    logic                        clear_done_reg;
    logic                        clear_done_next;
    logic                        we;
    logic [RA_W-1:0]             wa;
    logic [pga_pkg::COUNT_W-1:0] wd;

    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        clear_done_next = clear_done_reg;
        if (!clear_done_reg)
        begin
            clr_addr_next = clr_addr_reg + RA_W'(1);
            if (clr_addr_reg == RA_W'(RC_DEPTH - 1))
                clear_done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            clear_done_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg   <= clr_addr_next;
            clear_done_reg <= clear_done_next;
        end
    end

    // Sweep zeros until the clear is done, then take the execute-stage writes.
    always_comb
    begin
        if (!clear_done_reg)
        begin
            we = 1'b1;
            wa = clr_addr_reg;
            wd = '0;
        end
        else
        begin
            we = wr.en;
            wa = wr.page[RA_W-1:0];
            wd = wr.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_count <= mem[rd_page[RA_W-1:0]];
    end

    assign clear_done = clear_done_reg;

endmodule

`default_nettype wire
